// ===== sv/trls_pkg.sv =====
// Types, constants, saturating helpers and the sequencer program of the smoother.
package trls_pkg;

    // Field and datapath widths.
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int DT_W      = 16;
    localparam int LIM_W     = 16;
    localparam int RET_W     = 16;
    localparam int FRAC_W    = 16;
    localparam int RET_FRAC  = 8;
    localparam int K_W       = 40;
    localparam int COEF_W    = 44;
    localparam int MA_W      = 32;
    localparam int MB_W      = 22;
    localparam int PROD_W    = MA_W + MB_W;
    localparam int SUM_W     = 76;
    localparam int Q_W       = SUM_W - FRAC_W;
    localparam int PC_W      = 6;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Filter constants in Q6.16.
    localparam logic [MB_W-1:0] C_SPEED = MB_W'(87818);
    localparam logic [MB_W-1:0] C_ACCEL = MB_W'(237240);
    localparam logic [MB_W-1:0] C_JERK  = MB_W'(640287);

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ON   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF  = 2'd3;
    localparam logic [DATA_W-1:0]    RATE_RST = 32'd65536;
    localparam logic [RET_W-1:0]     RET_RST  = 16'd256;

    // Request types.
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    // Multiplier operand A selects.
    localparam logic [1:0] A_K_LO = 2'd0;
    localparam logic [1:0] A_K_HI = 2'd1;
    localparam logic [1:0] A_OPA  = 2'd2;

    // Multiplier operand B selects.
    localparam logic [3:0] B_RET   = 4'd0;
    localparam logic [3:0] B_CSPD  = 4'd1;
    localparam logic [3:0] B_CACC  = 4'd2;
    localparam logic [3:0] B_CJRK  = 4'd3;
    localparam logic [3:0] B_CS_LO = 4'd4;
    localparam logic [3:0] B_CS_HI = 4'd5;
    localparam logic [3:0] B_CA_LO = 4'd6;
    localparam logic [3:0] B_CA_HI = 4'd7;
    localparam logic [3:0] B_CJ_LO = 4'd8;
    localparam logic [3:0] B_CJ_HI = 4'd9;
    localparam logic [3:0] B_DT    = 4'd10;

    // Accumulator alignment of a product.
    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_MB = 2'd1;
    localparam logic [1:0] SH_MA = 2'd2;

    // Write-back and operand preparation operations.
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_K       = 4'd1;
    localparam logic [3:0] OP_CS      = 4'd2;
    localparam logic [3:0] OP_CA      = 4'd3;
    localparam logic [3:0] OP_CJ      = 4'd4;
    localparam logic [3:0] OP_T       = 4'd5;
    localparam logic [3:0] OP_ACC     = 4'd6;
    localparam logic [3:0] OP_SPD     = 4'd7;
    localparam logic [3:0] OP_VAL     = 4'd8;
    localparam logic [3:0] OP_PREP_TV = 4'd9;
    localparam logic [3:0] OP_PREP_DA = 4'd10;
    localparam logic [3:0] OP_PREP_DJ = 4'd11;
    localparam logic [3:0] OP_PREP_MA = 4'd12;
    localparam logic [3:0] OP_PREP_ST = 4'd13;

    // Jump conditions.
    localparam logic JMP_NONE      = 1'b0;
    localparam logic JMP_NOT_BELOW = 1'b1;

    // Program addresses.
    localparam logic [PC_W-1:0] PC_START = 6'd0;
    localparam logic [PC_W-1:0] PC_COEF  = 6'd3;
    localparam logic [PC_W-1:0] PC_FIN   = 6'd34;

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] target;
        logic [DT_W-1:0]          time_step;
        logic signed [DATA_W-1:0] load_value;
        logic signed [DATA_W-1:0] load_speed;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] filtered_value;
        logic signed [DATA_W-1:0] filtered_speed;
    } t_out_item;

    typedef struct packed {
        logic            mul_en;
        logic [1:0]      a_sel;
        logic [3:0]      b_sel;
        logic            acc_clr;
        logic [1:0]      sh_sel;
        logic [3:0]      op;
        logic            jmp;
        logic [PC_W-1:0] jmp_tgt;
        logic            last;
    } t_uword;

    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [DATA_W:0] s);
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? SAT_MIN : SAT_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        return sat_sum({a[DATA_W-1], a} + {b[DATA_W-1], b});
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        return sat_sum({a[DATA_W-1], a} - {b[DATA_W-1], b});
    endfunction

    // Magnitude as an unsigned word; the most negative value maps to 2^(DATA_W-1).
    function automatic logic [DATA_W-1:0] mag_of(input logic signed [DATA_W-1:0] x);
        return x[DATA_W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic t_uword mk(input logic mul_en, input logic [1:0] a_sel,
                                  input logic [3:0] b_sel, input logic acc_clr,
                                  input logic [1:0] sh_sel, input logic [3:0] op);
        t_uword uw;
        uw         = '0;
        uw.mul_en  = mul_en;
        uw.a_sel   = a_sel;
        uw.b_sel   = b_sel;
        uw.acc_clr = acc_clr;
        uw.sh_sel  = sh_sel;
        uw.op      = op;
        uw.jmp     = JMP_NONE;
        return uw;
    endfunction

    // Program of an update. A product issued at a step is first registered and then accumulated,
    // so a write-back that reads the accumulator sits after both of those writes.
    function automatic t_uword uc_rom(input logic [PC_W-1:0] pc);
        t_uword uw;
        uw = mk(1'b0, A_K_LO, B_RET, 1'b0, SH_0, OP_NONE);
        case (pc)
            6'd0: begin
                uw         = mk(1'b1, A_K_LO, B_RET, 1'b1, SH_0, OP_NONE);
                uw.jmp     = JMP_NOT_BELOW;
                uw.jmp_tgt = PC_COEF;
            end
            6'd2:  uw = mk(1'b0, A_K_LO, B_RET,   1'b0, SH_0,  OP_K);
            6'd3:  uw = mk(1'b1, A_K_LO, B_CSPD,  1'b1, SH_0,  OP_PREP_TV);
            6'd4:  uw = mk(1'b1, A_K_HI, B_CSPD,  1'b0, SH_MA, OP_NONE);
            6'd5:  uw = mk(1'b1, A_K_LO, B_CACC,  1'b1, SH_0,  OP_NONE);
            6'd6:  uw = mk(1'b1, A_K_HI, B_CACC,  1'b0, SH_MA, OP_CS);
            6'd7:  uw = mk(1'b1, A_K_LO, B_CJRK,  1'b1, SH_0,  OP_NONE);
            6'd8:  uw = mk(1'b1, A_K_HI, B_CJRK,  1'b0, SH_MA, OP_CA);
            6'd9:  uw = mk(1'b1, A_OPA,  B_CS_LO, 1'b1, SH_0,  OP_NONE);
            6'd10: uw = mk(1'b1, A_OPA,  B_CS_HI, 1'b0, SH_MB, OP_CJ);
            6'd12: uw = mk(1'b0, A_OPA,  B_RET,   1'b0, SH_0,  OP_T);
            6'd13: uw = mk(1'b0, A_OPA,  B_RET,   1'b0, SH_0,  OP_PREP_DA);
            6'd14: uw = mk(1'b1, A_OPA,  B_CA_LO, 1'b1, SH_0,  OP_NONE);
            6'd15: uw = mk(1'b1, A_OPA,  B_CA_HI, 1'b0, SH_MB, OP_NONE);
            6'd17: uw = mk(1'b0, A_OPA,  B_RET,   1'b0, SH_0,  OP_T);
            6'd18: uw = mk(1'b0, A_OPA,  B_RET,   1'b0, SH_0,  OP_PREP_DJ);
            6'd19: uw = mk(1'b1, A_OPA,  B_CJ_LO, 1'b1, SH_0,  OP_NONE);
            6'd20: uw = mk(1'b1, A_OPA,  B_CJ_HI, 1'b0, SH_MB, OP_NONE);
            6'd22: uw = mk(1'b0, A_OPA,  B_RET,   1'b0, SH_0,  OP_T);
            6'd23: uw = mk(1'b1, A_OPA,  B_DT,    1'b1, SH_0,  OP_NONE);
            6'd25: uw = mk(1'b0, A_OPA,  B_RET,   1'b0, SH_0,  OP_ACC);
            6'd26: uw = mk(1'b0, A_OPA,  B_RET,   1'b0, SH_0,  OP_PREP_MA);
            6'd27: uw = mk(1'b1, A_OPA,  B_DT,    1'b1, SH_0,  OP_NONE);
            6'd29: uw = mk(1'b0, A_OPA,  B_RET,   1'b0, SH_0,  OP_SPD);
            6'd30: uw = mk(1'b0, A_OPA,  B_RET,   1'b0, SH_0,  OP_PREP_ST);
            6'd31: uw = mk(1'b1, A_OPA,  B_DT,    1'b1, SH_0,  OP_NONE);
            6'd33: uw = mk(1'b0, A_OPA,  B_RET,   1'b0, SH_0,  OP_VAL);
            PC_FIN: begin
                uw      = mk(1'b0, A_OPA, B_RET, 1'b0, SH_0, OP_NONE);
                uw.last = 1'b1;
            end
            default: uw = mk(1'b0, A_K_LO, B_RET, 1'b0, SH_0, OP_NONE);
        endcase
        return uw;
    endfunction

endpackage

// ===== sv/third_order_rate_limited_smoother.sv =====
// Top level of the third-order rate-limited smoother with its microcoded datapath.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-------------------------------------
//  in       | i_in_valid / o_in_ready    | i_in  (trls_pkg::t_in_item)
//  out      | o_out_valid / i_out_ready  | o_out (trls_pkg::t_out_item)
//  cfg      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An update runs every sequencer step, skipping the return-rate steps when that rate does not
// apply; a load runs only the final step. The program is long because the single shared
// 32 x 22 multiplier takes every product of the update in turn.
// Reset (synchronous, active low) clears the state, the sequencer and the output valid,
// and holds both ready outputs low.
// A finished result waits in the output register; the final step stalls only while it is full.
module third_order_rate_limited_smoother (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  trls_pkg::t_in_item                    i_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output trls_pkg::t_out_item                   o_out,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [trls_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [trls_pkg::DATA_W-1:0]           i_cfg_data
);

    // Configuration registers.
    logic [trls_pkg::DATA_W-1:0] r_rate;
    logic [trls_pkg::RET_W-1:0]  r_ret;
    logic [trls_pkg::LIM_W-1:0]  r_on;
    logic [trls_pkg::LIM_W-1:0]  r_off;

    // Sequencer and pipeline control.
    logic                         r_busy;
    logic [trls_pkg::PC_W-1:0]    r_pc;
    logic                         r_p_en;
    logic                         r_p_clr;
    logic [1:0]                   r_p_sh;
    logic                         r_out_valid;

    // Filter state.
    logic signed [trls_pkg::DATA_W-1:0] r_val;
    logic signed [trls_pkg::DATA_W-1:0] r_spd;
    logic signed [trls_pkg::DATA_W-1:0] r_accel;

    // Per-transaction operands and datapath registers.
    logic signed [trls_pkg::DATA_W-1:0] r_tgt;
    logic [trls_pkg::DT_W-1:0]          r_dt;
    logic                               r_below;
    logic                               r_use_off;
    logic [trls_pkg::K_W-1:0]           r_k;
    logic [trls_pkg::COEF_W-1:0]        r_cs;
    logic [trls_pkg::COEF_W-1:0]        r_ca;
    logic [trls_pkg::COEF_W-1:0]        r_cj;
    logic [trls_pkg::MA_W-1:0]          r_opa;
    logic                               r_neg;
    logic signed [trls_pkg::DATA_W-1:0] r_t;
    logic [trls_pkg::PROD_W-1:0]        r_prod;
    logic [trls_pkg::SUM_W-1:0]         r_sum;
    trls_pkg::t_out_item                r_out;

    trls_pkg::t_uword                   uw;
    logic                               in_acc;
    logic                               out_free;
    logic                               step_en;
    logic [trls_pkg::MA_W-1:0]          mul_a;
    logic [trls_pkg::MB_W-1:0]          mul_b;
    logic [trls_pkg::SUM_W-1:0]         prod_ext;
    logic [trls_pkg::SUM_W-1:0]         prod_al;
    logic [trls_pkg::SUM_W-1:0]         n_sum;
    logic [trls_pkg::Q_W-1:0]           q;
    logic                               pos_ovf;
    logic                               neg_ovf;
    logic [trls_pkg::DATA_W-1:0]        mag_sat;
    logic signed [trls_pkg::DATA_W-1:0] mres;
    logic signed [trls_pkg::DATA_W-1:0] sub_a;
    logic signed [trls_pkg::DATA_W-1:0] sub_b;
    logic signed [trls_pkg::DATA_W-1:0] diff;
    logic [trls_pkg::DATA_W-1:0]        spd_mag;
    logic [trls_pkg::DATA_W-1:0]        lim;
    logic [trls_pkg::DATA_W-1:0]        tgt_mag;
    logic [trls_pkg::DATA_W-1:0]        val_mag;
    logic                               in_below;
    logic                               in_opposite;

    assign uw          = trls_pkg::uc_rom(r_pc);
    assign o_in_ready  = i_rst_n && !r_busy;
    assign o_cfg_ready = i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign step_en     = r_busy && !(uw.last && !out_free);

    // Return rate and limit choice are decided on the value held before the step.
    assign tgt_mag     = trls_pkg::mag_of(i_in.target);
    assign val_mag     = trls_pkg::mag_of(r_val);
    assign in_below    = tgt_mag < val_mag;
    assign in_opposite = (i_in.target[trls_pkg::DATA_W-1] && !r_val[trls_pkg::DATA_W-1]
                          && (r_val != '0))
                      || (!i_in.target[trls_pkg::DATA_W-1] && (i_in.target != '0)
                          && r_val[trls_pkg::DATA_W-1]);

    always_comb begin
        case (uw.a_sel)
            trls_pkg::A_K_LO: mul_a = r_k[trls_pkg::MA_W-1:0];
            trls_pkg::A_K_HI: mul_a = trls_pkg::MA_W'(r_k[trls_pkg::K_W-1:trls_pkg::MA_W]);
            trls_pkg::A_OPA:  mul_a = r_opa;
            default:          mul_a = '0;
        endcase
    end

    always_comb begin
        case (uw.b_sel)
            trls_pkg::B_RET:   mul_b = trls_pkg::MB_W'(r_ret);
            trls_pkg::B_CSPD:  mul_b = trls_pkg::C_SPEED;
            trls_pkg::B_CACC:  mul_b = trls_pkg::C_ACCEL;
            trls_pkg::B_CJRK:  mul_b = trls_pkg::C_JERK;
            trls_pkg::B_CS_LO: mul_b = r_cs[trls_pkg::MB_W-1:0];
            trls_pkg::B_CS_HI: mul_b = r_cs[trls_pkg::COEF_W-1:trls_pkg::MB_W];
            trls_pkg::B_CA_LO: mul_b = r_ca[trls_pkg::MB_W-1:0];
            trls_pkg::B_CA_HI: mul_b = r_ca[trls_pkg::COEF_W-1:trls_pkg::MB_W];
            trls_pkg::B_CJ_LO: mul_b = r_cj[trls_pkg::MB_W-1:0];
            trls_pkg::B_CJ_HI: mul_b = r_cj[trls_pkg::COEF_W-1:trls_pkg::MB_W];
            trls_pkg::B_DT:    mul_b = trls_pkg::MB_W'(r_dt);
            default:           mul_b = '0;
        endcase
    end

    assign prod_ext = trls_pkg::SUM_W'(r_prod);

    always_comb begin
        case (r_p_sh)
            trls_pkg::SH_MB: prod_al = prod_ext << trls_pkg::MB_W;
            trls_pkg::SH_MA: prod_al = prod_ext << trls_pkg::MA_W;
            default:         prod_al = prod_ext;
        endcase
        n_sum = (r_p_clr ? '0 : r_sum) + prod_al;
    end

    // Product magnitude shifted to Q16.16, saturated with the sign held in r_neg.
    always_comb begin
        q       = r_sum[trls_pkg::SUM_W-1:trls_pkg::FRAC_W];
        pos_ovf = |q[trls_pkg::Q_W-1:trls_pkg::DATA_W-1];
        neg_ovf = (|q[trls_pkg::Q_W-1:trls_pkg::DATA_W])
               || (q[trls_pkg::DATA_W-1] && (|q[trls_pkg::DATA_W-2:0]));
        if (r_neg) begin
            mag_sat = neg_ovf ? trls_pkg::SAT_MIN : q[trls_pkg::DATA_W-1:0];
        end else begin
            mag_sat = pos_ovf ? trls_pkg::SAT_MAX : q[trls_pkg::DATA_W-1:0];
        end
        mres = r_neg ? (~mag_sat + 1'b1) : mag_sat;
    end

    always_comb begin
        case (uw.op)
            trls_pkg::OP_PREP_DA: begin
                sub_a = r_t;
                sub_b = r_spd;
            end
            trls_pkg::OP_PREP_DJ: begin
                sub_a = r_t;
                sub_b = r_accel;
            end
            default: begin
                sub_a = r_tgt;
                sub_b = r_val;
            end
        endcase
        diff    = trls_pkg::sat_sub(sub_a, sub_b);
        spd_mag = trls_pkg::mag_of(r_spd);
        lim     = {(r_use_off ? r_off : r_on), {trls_pkg::FRAC_W{1'b0}}};
    end

    // Configuration, sequencer control and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= trls_pkg::RATE_RST;
            r_ret       <= trls_pkg::RET_RST;
            r_on        <= '0;
            r_off       <= '0;
            r_busy      <= 1'b0;
            r_pc        <= trls_pkg::PC_START;
            r_p_en      <= 1'b0;
            r_p_clr     <= 1'b0;
            r_p_sh      <= trls_pkg::SH_0;
            r_out_valid <= 1'b0;
            r_val       <= '0;
            r_spd       <= '0;
            r_accel     <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    trls_pkg::CFG_RATE: r_rate <= i_cfg_data;
                    trls_pkg::CFG_RET:  r_ret  <= i_cfg_data[trls_pkg::RET_W-1:0];
                    trls_pkg::CFG_ON:   r_on   <= i_cfg_data[trls_pkg::LIM_W-1:0];
                    trls_pkg::CFG_OFF:  r_off  <= i_cfg_data[trls_pkg::LIM_W-1:0];
                    default: ;
                endcase
            end

            r_p_en  <= step_en && uw.mul_en;
            r_p_clr <= uw.acc_clr;
            r_p_sh  <= uw.sh_sel;

            if (in_acc) begin
                r_busy <= 1'b1;
                if (i_in.req_type == trls_pkg::REQ_LOAD) begin
                    r_pc    <= trls_pkg::PC_FIN;
                    r_val   <= i_in.load_value;
                    r_spd   <= i_in.load_speed;
                    r_accel <= '0;
                end else begin
                    r_pc <= trls_pkg::PC_START;
                end
            end else if (step_en) begin
                if (uw.last) begin
                    r_busy <= 1'b0;
                end else if (uw.jmp == trls_pkg::JMP_NOT_BELOW && !r_below) begin
                    r_pc <= uw.jmp_tgt;
                end else begin
                    r_pc <= trls_pkg::PC_W'(r_pc + 1'b1);
                end
                unique case (uw.op)
                    trls_pkg::OP_ACC: r_accel <= trls_pkg::sat_add(r_accel, mres);
                    trls_pkg::OP_SPD: r_spd   <= trls_pkg::sat_add(r_spd, mres);
                    trls_pkg::OP_VAL: r_val   <= trls_pkg::sat_add(r_val, mres);
                    default: ;
                endcase
            end

            if (step_en && uw.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tgt     <= i_in.target;
            r_dt      <= i_in.time_step;
            r_below   <= in_below;
            r_use_off <= !in_opposite && in_below;
            r_k       <= trls_pkg::K_W'(r_rate);
        end
        if (step_en && uw.mul_en) begin
            r_prod <= trls_pkg::PROD_W'(mul_a) * trls_pkg::PROD_W'(mul_b);
        end
        if (r_p_en) begin
            r_sum <= n_sum;
        end
        if (step_en) begin
            unique case (uw.op) inside
                trls_pkg::OP_K:  r_k  <= r_sum[trls_pkg::K_W+trls_pkg::RET_FRAC-1:
                                               trls_pkg::RET_FRAC];
                trls_pkg::OP_CS: r_cs <= r_sum[trls_pkg::COEF_W+trls_pkg::FRAC_W-1:
                                               trls_pkg::FRAC_W];
                trls_pkg::OP_CA: r_ca <= r_sum[trls_pkg::COEF_W+trls_pkg::FRAC_W-1:
                                               trls_pkg::FRAC_W];
                trls_pkg::OP_CJ: r_cj <= r_sum[trls_pkg::COEF_W+trls_pkg::FRAC_W-1:
                                               trls_pkg::FRAC_W];
                trls_pkg::OP_T: begin
                    r_t   <= mres;
                    r_opa <= mag_sat;
                end
                trls_pkg::OP_PREP_TV, trls_pkg::OP_PREP_DA, trls_pkg::OP_PREP_DJ: begin
                    r_opa <= trls_pkg::mag_of(diff);
                    r_neg <= diff[trls_pkg::DATA_W-1];
                end
                trls_pkg::OP_PREP_MA: begin
                    r_opa <= trls_pkg::mag_of(r_accel);
                    r_neg <= r_accel[trls_pkg::DATA_W-1];
                end
                trls_pkg::OP_PREP_ST: begin
                    r_opa <= (spd_mag < lim) ? spd_mag : lim;
                    r_neg <= r_spd[trls_pkg::DATA_W-1];
                end
                default: ;
            endcase
            if (uw.last) begin
                r_out.filtered_value <= r_val;
                r_out.filtered_speed <= r_spd;
            end
        end
    end

    // An accepted transaction always starts the program at its entry or at the final step.
    a_accept_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_busy && (r_pc == trls_pkg::PC_START || r_pc == trls_pkg::PC_FIN)))
        else $error("accepted transaction did not start the sequencer");

    // A result appears only when the final step has run.
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy && uw.last))
        else $error("result presented without the final step");

    // The filter state holds while the sequencer is idle and nothing is accepted.
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n && !r_busy && !in_acc)
        |-> ($stable(r_val) && $stable(r_spd) && $stable(r_accel)))
        else $error("filter state changed while idle");

endmodule
